>>> rtl/core/subset_orbit_minimum_defines.svh
// Assertion macros shared by the RTL. Both expect i_clk and i_rst_n in scope.
`ifndef SUBSET_ORBIT_MINIMUM_DEFINES_SVH
`define SUBSET_ORBIT_MINIMUM_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define SOM_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define SOM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`else

`define SOM_ASSERT_IMPLY(lbl, ante, cons)
`define SOM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/core/som_pkg.sv
package som_pkg;

    localparam int POINTS    = 64;
    localparam int MASK_W    = 64;
    localparam int PT_W      = 6;
    localparam int ROW_W     = 4;
    localparam int DEG_W     = 7;
    localparam int ACT_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd1;

    localparam logic [DEG_W-1:0] DEGREE_MAX = 7'd64;

    // One item as it travels along the chain of cells.
    typedef struct packed {
        logic              valid;
        logic              is_load;
        logic [ROW_W-1:0]  row;
        logic [PT_W-1:0]   src;
        logic [PT_W-1:0]   tgt;
        logic [MASK_W-1:0] mask;
        logic [MASK_W-1:0] best;
        logic              minimal;
        logic              bad;
        logic              last;
    } t_item;

endpackage

>>> rtl/core/som_channels.sv
interface som_in_if;
    import som_pkg::*;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [ROW_W-1:0]  perm_row;
    logic [PT_W-1:0]   source_point;
    logic [PT_W-1:0]   target_point;
    logic [MASK_W-1:0] query_mask;
    logic              batch_last;

    modport source (output valid, opcode, perm_row, source_point, target_point,
                    query_mask, batch_last, input ready);
    modport sink   (input valid, opcode, perm_row, source_point, target_point,
                    query_mask, batch_last, output ready);
endinterface

interface som_out_if;
    import som_pkg::*;
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] canonical_mask;
    logic              is_minimal;
    logic              bad_mask;
    logic              batch_end;

    modport source (output valid, canonical_mask, is_minimal, bad_mask, batch_end,
                    input ready);
    modport sink   (input valid, canonical_mask, is_minimal, bad_mask, batch_end,
                    output ready);
endinterface

interface som_cfg_if;
    import som_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DEG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/som_cell.sv
module som_cell
    import som_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_active,
    input  t_item i_item,
    output t_item o_item
);

    logic [PT_W-1:0]   r_perm [POINTS];
    t_item             r_item;
    t_item             n_item;
    logic [MASK_W-1:0] image;
    logic              row_hit;

    assign row_hit = (32'(i_item.row) == IDX);

    // Each set bit i of the mask lands on bit perm[i] of the image.
    always_comb begin
        image = '0;
        for (int i = 0; i < POINTS; i++) begin
            if (i_item.mask[i]) begin
                image[r_perm[i]] = 1'b1;
            end
        end
    end

    always_comb begin
        n_item = i_item;
        if (i_item.valid && !i_item.is_load && !i_item.bad && i_active) begin
            if (image < i_item.best) begin
                n_item.best = image;
            end
            if (image < i_item.mask) begin
                n_item.minimal = 1'b0;
            end
        end
    end

    // A load is applied only when it reaches this cell, so it stays in order
    // with the queries around it.
    always_ff @(posedge i_clk) begin
        if (i_en && i_item.valid && i_item.is_load && row_hit) begin
            r_perm[i_item.src] <= i_item.tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

>>> rtl/core/subset_orbit_minimum.sv
// Channel   Direction  Carries
// i_in      sink       opcode, perm_row, source_point, target_point, query_mask, batch_last
// o_out     source     canonical_mask, is_minimal, bad_mask, batch_end
// i_cfg     sink       index, data (register writes, always ready)
//
// One item is taken per cycle while the output is not stalled. A query result is registered
// by the entry register at the edge that accepts its item, then by one cell per permutation
// row and by the output register, where it becomes valid. Loads travel the same chain and
// are written by their row's cell.
// Reset is synchronous and clears valid flags and the config registers; table rows are not cleared.
// A stalled output freezes the whole chain, and the input is not ready meanwhile.
`include "subset_orbit_minimum_defines.svh"

module subset_orbit_minimum
    import som_pkg::*;
#(
    parameter int MAX_PERMS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    som_in_if.sink     i_in,
    som_out_if.source  o_out,
    som_cfg_if.sink    i_cfg
);

    logic [DEG_W-1:0]     r_degree;
    logic [ACT_W-1:0]     r_active_perms;
    t_item                r_entry;
    t_item                n_entry;
    t_item                w_stage [MAX_PERMS+1];
    t_item                w_tail;
    logic [MAX_PERMS-1:0] row_active;
    logic                 advance;
    logic [DEG_W-1:0]     eff_degree;
    logic [MASK_W-1:0]    valid_bits;

    logic                 r_out_valid;
    logic [MASK_W-1:0]    r_out_mask;
    logic                 r_out_minimal;
    logic                 r_out_bad;
    logic                 r_out_last;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree       <= DEGREE_MAX;
            r_active_perms <= ACT_W'(1);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DEGREE: r_degree       <= i_cfg.data;
                CFG_ACTIVE: r_active_perms <= i_cfg.data[ACT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        if (r_degree == '0) begin
            eff_degree = DEG_W'(1);
        end else if (r_degree > DEGREE_MAX) begin
            eff_degree = DEGREE_MAX;
        end else begin
            eff_degree = r_degree;
        end
    end

    assign valid_bits = (eff_degree == DEGREE_MAX) ? {MASK_W{1'b1}}
                      : ~({MASK_W{1'b1}} << eff_degree[PT_W-1:0]);

    // The whole chain moves together whenever the output register can take an item.
    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = advance;

    always_comb begin
        n_entry.valid   = i_in.valid;
        n_entry.is_load = (i_in.opcode == OP_LOAD);
        n_entry.row     = i_in.perm_row;
        n_entry.src     = i_in.source_point;
        n_entry.tgt     = i_in.target_point;
        n_entry.mask    = i_in.query_mask;
        n_entry.best    = i_in.query_mask;
        n_entry.minimal = 1'b1;
        n_entry.bad     = |(i_in.query_mask & ~valid_bits);
        n_entry.last    = i_in.batch_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (advance) begin
            r_entry <= n_entry;
        end
    end

    assign w_stage[0] = r_entry;

    for (genvar r = 0; r < MAX_PERMS; r++) begin : g_cell
        assign row_active[r] = (32'(r_active_perms) > r);

        som_cell #(
            .IDX (r)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (advance),
            .i_active (row_active[r]),
            .i_item   (w_stage[r]),
            .o_item   (w_stage[r+1])
        );
    end

    assign w_tail = w_stage[MAX_PERMS];

    // Loads leave the chain here; only query results reach the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= w_tail.valid && !w_tail.is_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_mask    <= w_tail.bad ? '0 : w_tail.best;
            r_out_minimal <= w_tail.minimal && !w_tail.bad;
            r_out_bad     <= w_tail.bad;
            r_out_last    <= w_tail.last;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.canonical_mask = r_out_mask;
    assign o_out.is_minimal     = r_out_minimal;
    assign o_out.bad_mask       = r_out_bad;
    assign o_out.batch_end      = r_out_last;

    `SOM_ASSERT_IMPLY(a_bad_result_zero, r_out_valid && r_out_bad, (r_out_mask == '0) && !r_out_minimal)

    // Loads and bad masks carry best equal to mask, so these hold for every item.
    `SOM_ASSERT_IMPLY(a_best_not_above, w_tail.valid, w_tail.best <= w_tail.mask)

    `SOM_ASSERT_IMPLY(a_minimal_keeps_mask, w_tail.valid && w_tail.minimal, w_tail.best == w_tail.mask)

    `SOM_ASSERT_NEXT(a_stall_holds_tail, w_tail.valid && !advance, w_tail.valid)

endmodule
